FILE: rtl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ck, rn, a, c)
`define ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

FILE: rtl/epcc_pkg.sv
// Types, constants and helper functions of the primitive/conservative converter.
// No dependencies.
package epcc_pkg;
	localparam int DIV_STAGES = 48;

	localparam logic FUNC_FWD = 1'b0;
	localparam logic FUNC_REV = 1'b1;

	localparam logic REG_GM1 = 1'b0;
	localparam logic REG_INV = 1'b1;

	localparam logic [17:0] GM1_RST = 18'd26214;
	localparam logic [30:0] INV_RST = 31'd163840;

	localparam logic [63:0] KE_CAP = 64'h0000_8000_0000_0000;
	localparam logic signed [49:0] BR_MAX = 50'sh1FFF_FFFF_FFFF;

	typedef struct packed {
		logic [31:0] rem;
		logic [47:0] nq;
		logic        neg;
	} lane_t;

	typedef struct packed {
		logic             func;
		logic [31:0]      q0;
		logic [2:0][31:0] qm;
		logic [31:0]      q4;
		logic [31:0]      dv;
		lane_t [2:0]      ln;
	} div_t;

	typedef struct packed {
		logic [31:0] q0;
		logic [31:0] q1;
		logic [31:0] q2;
		logic [31:0] q3;
		logic [31:0] q4;
		logic        zd;
		logic        sat;
	} res_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] v;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] x);
		sat_t r;
		if (x > 64'sd2147483647) begin
			r.sat = 1'b1;
			r.v = 32'h7FFF_FFFF;
		end else if (x < -64'sd2147483648) begin
			r.sat = 1'b1;
			r.v = 32'h8000_0000;
		end else begin
			r.sat = 1'b0;
			r.v = x[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction
endpackage

FILE: rtl/euler_primitive_conservative_convert_top.sv
// Top level of the ideal-gas primitive/conservative converter.
// Depends on epcc_pkg, epcc_div, epcc_post, epcc_obuf and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall, func, in_q0..in_q4) takes one grid node per
//   transaction; output channel (out_valid/out_stall, out_q0..out_q4,
//   zero_density, saturated) returns one result per transaction, in order.
//   func = 0 converts primitive to conservative, func = 1 the reverse.
//   Throughput: one transaction per cycle while in_stall is low. Pipeline: 1 setup
//   stage, 48 divider stages (one quotient bit per stage, three lanes) and 7
//   arithmetic stages before the output buffer.
//   The divider runs for both modes so every item takes the same path.
//   A two-entry output buffer sits at the end; the whole pipeline freezes only
//   when both entries are occupied, so in_stall is a register output and the
//   block keeps accepting while a single result waits.
//   Reset clears all valid bits and loads the default gamma registers.
//   Registers: 0x0 gamma_minus_one, 0x4 inv_gamma_minus_one (APB, no wait).
`include "assert_macros.svh"
module euler_primitive_conservative_convert_top import epcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] in_q0,
	input  logic [31:0] in_q1,
	input  logic [31:0] in_q2,
	input  logic [31:0] in_q3,
	input  logic [31:0] in_q4,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_q0,
	output logic [31:0] out_q1,
	output logic [31:0] out_q2,
	output logic [31:0] out_q3,
	output logic [31:0] out_q4,
	output logic        zero_density,
	output logic        saturated,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [17:0] gm1_q;
	logic [30:0] inv_q;
	logic        adv, full;
	div_t        setup_d, div_out;
	logic        div_v, post_v;
	res_t        post_r, res;
	logic [2:0][31:0] qm;
	logic [2:0][31:0] mm;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_INV) ? {1'b0, inv_q} : {14'd0, gm1_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm1_q <= GM1_RST;
			inv_q <= INV_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_GM1: gm1_q <= pwdata[17:0];
				REG_INV: inv_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	assign adv = !full;
	assign in_stall = full;

	// numerator |m|*2^16 + |rho|/2 for round-to-nearest quotients
	assign qm = {in_q3, in_q2, in_q1};
	always_comb begin
		setup_d.func = func;
		setup_d.q0 = in_q0;
		setup_d.qm = qm;
		setup_d.q4 = in_q4;
		setup_d.dv = mag32(in_q0);
		for (int i = 0; i < 3; i++) begin
			mm[i] = mag32(qm[i]);
			setup_d.ln[i].rem = '0;
			setup_d.ln[i].nq = {mm[i], 16'd0} + {17'd0, setup_d.dv[31:1]};
			setup_d.ln[i].neg = qm[i][31] ^ in_q0[31];
		end
	end

	epcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (in_valid),
		.in_d   (setup_d),
		.out_v  (div_v),
		.out_d  (div_out)
	);

	epcc_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_v   (div_v),
		.in_d   (div_out),
		.gm1    (gm1_q),
		.inv    (inv_q),
		.out_v  (post_v),
		.out_r  (post_r)
	);

	epcc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (post_v && adv),
		.din       (post_r),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (res)
	);

	assign out_q0 = res.q0;
	assign out_q1 = res.q1;
	assign out_q2 = res.q2;
	assign out_q3 = res.q3;
	assign out_q4 = res.q4;
	assign zero_density = res.zd;
	assign saturated = res.sat;

	`ASSERT_IMP(a_zd_zero, clk, arst_n, out_valid && zero_density, out_q0 == 32'd0 && out_q4 == 32'd0)
	`ASSERT_IMP(a_zd_nosat, clk, arst_n, out_valid && zero_density, !saturated)
endmodule

FILE: rtl/epcc_div.sv
// Pipelined restoring divider: three lanes, one quotient bit per stage.
// Depends on epcc_pkg.
module epcc_div import epcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_v,
	input  div_t in_d,
	output logic out_v,
	output div_t out_d
);
	logic [DIV_STAGES:0] v_s;
	div_t d_s [DIV_STAGES+1];

	function automatic div_t div_step(input div_t x);
		div_t y;
		logic [32:0] rs;
		logic [32:0] df;
		y = x;
		for (int i = 0; i < 3; i++) begin
			rs = {x.ln[i].rem, x.ln[i].nq[47]};
			df = rs - {1'b0, x.dv};
			if (!df[32]) begin
				y.ln[i].rem = df[31:0];
				y.ln[i].nq = {x.ln[i].nq[46:0], 1'b1};
			end else begin
				y.ln[i].rem = rs[31:0];
				y.ln[i].nq = {x.ln[i].nq[46:0], 1'b0};
			end
		end
		return y;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[DIV_STAGES-1:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0] <= in_d;
		end
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				d_s[k] <= div_step(d_s[k-1]);
			end
		end
	end

	assign out_v = v_s[DIV_STAGES];
	assign out_d = d_s[DIV_STAGES];
endmodule

FILE: rtl/epcc_post.sv
// Post-divide stages: velocity select, products, kinetic term, energy/pressure.
// Depends on epcc_pkg.
module epcc_post import epcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_v,
	input  div_t        in_d,
	input  logic [17:0] gm1,
	input  logic [30:0] inv,
	output logic        out_v,
	output res_t        out_r
);
	typedef struct packed {
		logic func; logic zd; logic sat;
		logic [31:0] q0; logic [31:0] q4;
		logic [2:0][31:0] vel;
	} p1_t;
	typedef struct packed {
		logic func; logic zd; logic sat;
		logic [31:0] q0; logic [31:0] q4;
		logic [2:0][31:0] vel;
		logic [2:0][63:0] sq;
		logic [2:0][63:0] mom;
		logic [63:0] pe;
	} p2_t;
	typedef struct packed {
		logic func; logic zd; logic sat;
		logic [31:0] q0; logic [31:0] q4;
		logic [2:0][31:0] r;
		logic [47:0] v2;
		logic [47:0] pe;
	} p3_t;
	typedef struct packed {
		logic func; logic zd; logic sat;
		logic [31:0] q0; logic [31:0] q4;
		logic [2:0][31:0] r;
		logic [47:0] pe;
		logic [63:0] plo;
		logic [47:0] phi;
	} p4_t;
	typedef struct packed {
		logic func; logic zd; logic sat;
		logic [31:0] q0; logic [31:0] q4;
		logic [2:0][31:0] r;
		logic [47:0] pe;
		logic [48:0] k;
	} p5_t;
	typedef struct packed {
		logic func; logic zd; logic sat;
		logic [31:0] q0;
		logic [2:0][31:0] r;
		logic [31:0] e;
		logic [45:0] br;
	} p6_t;
	typedef struct packed {
		logic func; logic zd; logic sat;
		logic [31:0] q0;
		logic [2:0][31:0] r;
		logic [31:0] e;
		logic [63:0] prod;
	} p7_t;

	logic [6:0] vld_s;
	p1_t p1_d, p1_s;
	p2_t p2_d, p2_s;
	p3_t p3_d, p3_s;
	p4_t p4_d, p4_s;
	p5_t p5_d, p5_s;
	p6_t p6_d, p6_s;
	p7_t p7_d, p7_s;

	// stage 1: velocity select and saturation of quotients
	always_comb begin
		logic [47:0] q;
		p1_d.func = in_d.func;
		p1_d.zd = (in_d.func == FUNC_REV) && (in_d.q0 == 32'd0);
		p1_d.sat = 1'b0;
		p1_d.q0 = in_d.q0;
		p1_d.q4 = in_d.q4;
		for (int i = 0; i < 3; i++) begin
			q = in_d.ln[i].nq;
			if (in_d.func == FUNC_FWD) begin
				p1_d.vel[i] = in_d.qm[i];
			end else if (in_d.ln[i].neg) begin
				if (q > 48'h0000_8000_0000) begin
					p1_d.sat = 1'b1;
					p1_d.vel[i] = 32'h8000_0000;
				end else begin
					p1_d.vel[i] = 32'd0 - q[31:0];
				end
			end else begin
				if (q > 48'h0000_7FFF_FFFF) begin
					p1_d.sat = 1'b1;
					p1_d.vel[i] = 32'h7FFF_FFFF;
				end else begin
					p1_d.vel[i] = q[31:0];
				end
			end
		end
	end

	// stage 2: squares, momenta, pressure term
	always_comb begin
		p2_d.func = p1_s.func;
		p2_d.zd = p1_s.zd;
		p2_d.sat = p1_s.sat;
		p2_d.q0 = p1_s.q0;
		p2_d.q4 = p1_s.q4;
		p2_d.vel = p1_s.vel;
		for (int i = 0; i < 3; i++) begin
			p2_d.sq[i] = 64'($signed(p1_s.vel[i]) * $signed(p1_s.vel[i]));
			p2_d.mom[i] = 64'($signed(p1_s.q0) * $signed(p1_s.vel[i]));
		end
		p2_d.pe = 64'($signed(p1_s.q4) * $signed({1'b0, inv}));
	end

	// stage 3: speed squared, rounding of products
	always_comb begin
		logic [63:0] sum;
		logic [63:0] pr;
		logic signed [63:0] t;
		sat_t s;
		p3_d.func = p2_s.func;
		p3_d.zd = p2_s.zd;
		p3_d.sat = p2_s.sat;
		p3_d.q0 = p2_s.q0;
		p3_d.q4 = p2_s.q4;
		sum = p2_s.sq[0] + p2_s.sq[1] + p2_s.sq[2] + 64'd32768;
		p3_d.v2 = sum[63:16];
		pr = p2_s.pe + 64'd32768;
		p3_d.pe = pr[63:16];
		for (int i = 0; i < 3; i++) begin
			t = ($signed(p2_s.mom[i]) + 64'sd32768) >>> 16;
			s = sat32(t);
			if (p2_s.func == FUNC_FWD) begin
				p3_d.r[i] = s.v;
				if (s.sat) begin
					p3_d.sat = 1'b1;
				end
			end else begin
				p3_d.r[i] = p2_s.vel[i];
			end
		end
	end

	// stage 4: |rho| * v2 as two partial products
	always_comb begin
		logic [31:0] a;
		a = mag32(p3_s.q0);
		p4_d.func = p3_s.func;
		p4_d.zd = p3_s.zd;
		p4_d.sat = p3_s.sat;
		p4_d.q0 = p3_s.q0;
		p4_d.q4 = p3_s.q4;
		p4_d.r = p3_s.r;
		p4_d.pe = p3_s.pe;
		p4_d.plo = 64'(a * p3_s.v2[31:0]);
		p4_d.phi = 48'(a * p3_s.v2[47:32]);
	end

	// stage 5: kinetic term, clamp, sign of rho
	always_comb begin
		logic [63:0] ku;
		logic [47:0] kc;
		p5_d.func = p4_s.func;
		p5_d.zd = p4_s.zd;
		p5_d.sat = p4_s.sat;
		p5_d.q0 = p4_s.q0;
		p5_d.q4 = p4_s.q4;
		p5_d.r = p4_s.r;
		p5_d.pe = p4_s.pe;
		ku = {1'b0, p4_s.phi, 15'd0} + {17'd0, p4_s.plo[63:17]} + {63'd0, p4_s.plo[16]};
		if (ku > KE_CAP) begin
			kc = KE_CAP[47:0];
			p5_d.sat = 1'b1;
		end else begin
			kc = ku[47:0];
		end
		p5_d.k = p4_s.q0[31] ? (49'd0 - {1'b0, kc}) : {1'b0, kc};
	end

	// stage 6: forward energy, reverse bracket
	always_comb begin
		logic [63:0] es;
		logic signed [49:0] b;
		sat_t s;
		p6_d.func = p5_s.func;
		p6_d.zd = p5_s.zd;
		p6_d.sat = p5_s.sat;
		p6_d.q0 = p5_s.q0;
		p6_d.r = p5_s.r;
		es = {{16{p5_s.pe[47]}}, p5_s.pe} + {{15{p5_s.k[48]}}, p5_s.k};
		s = sat32($signed(es));
		p6_d.e = s.v;
		b = $signed({{18{p5_s.q4[31]}}, p5_s.q4}) - $signed({p5_s.k[48], p5_s.k});
		if (b > BR_MAX) begin
			p6_d.br = BR_MAX[45:0];
			if (p5_s.func == FUNC_REV) p6_d.sat = 1'b1;
		end else if (b < -BR_MAX) begin
			p6_d.br = 46'd0 - BR_MAX[45:0];
			if (p5_s.func == FUNC_REV) p6_d.sat = 1'b1;
		end else begin
			p6_d.br = b[45:0];
		end
		if (p5_s.func == FUNC_FWD && s.sat) begin
			p6_d.sat = 1'b1;
		end
	end

	// stage 7: pressure product
	always_comb begin
		p7_d.func = p6_s.func;
		p7_d.zd = p6_s.zd;
		p7_d.sat = p6_s.sat;
		p7_d.q0 = p6_s.q0;
		p7_d.r = p6_s.r;
		p7_d.e = p6_s.e;
		p7_d.prod = 64'($signed(p6_s.br) * $signed({1'b0, gm1}));
	end

	// result: pressure rounding and final select
	always_comb begin
		logic signed [63:0] t;
		sat_t s;
		t = ($signed(p7_s.prod) + 64'sd32768) >>> 16;
		s = sat32(t);
		out_r.q0 = p7_s.q0;
		if (p7_s.zd) begin
			out_r.q1 = '0;
			out_r.q2 = '0;
			out_r.q3 = '0;
			out_r.q4 = '0;
			out_r.zd = 1'b1;
			out_r.sat = 1'b0;
		end else begin
			out_r.q1 = p7_s.r[0];
			out_r.q2 = p7_s.r[1];
			out_r.q3 = p7_s.r[2];
			out_r.zd = 1'b0;
			if (p7_s.func == FUNC_FWD) begin
				out_r.q4 = p7_s.e;
				out_r.sat = p7_s.sat;
			end else begin
				out_r.q4 = s.v;
				out_r.sat = p7_s.sat | s.sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[5:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s <= p1_d;
			p2_s <= p2_d;
			p3_s <= p3_d;
			p4_s <= p4_d;
			p5_s <= p5_d;
			p6_s <= p6_d;
			p7_s <= p7_d;
		end
	end

	assign out_v = vld_s[6];
endmodule

FILE: rtl/epcc_obuf.sv
// Two-entry output buffer that decouples the pipeline from the receiver.
// Depends on epcc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module epcc_obuf import epcc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t dout
);
	localparam logic [1:0] CNT_EMPTY = 2'd0;
	localparam logic [1:0] CNT_ONE = 2'd1;
	localparam logic [1:0] CNT_FULL = 2'd2;

	logic [1:0] cnt_q;
	logic       pop;
	res_t       head_q, spare_q;

	assign out_valid = (cnt_q != CNT_EMPTY);
	assign pop = out_valid && !out_stall;
	assign full = (cnt_q == CNT_FULL);
	assign dout = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_EMPTY;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			CNT_EMPTY: begin
				if (push) head_q <= din;
			end
			CNT_ONE: begin
				if (push && pop) head_q <= din;
				else if (push) spare_q <= din;
			end
			CNT_FULL: begin
				if (pop) head_q <= spare_q;
			end
			default: ;
		endcase
	end

	`ASSERT_IMP(a_no_push_full, clk, arst_n, cnt_q == CNT_FULL, !push)
	`ASSERT_NXT(a_full_holds, clk, arst_n, cnt_q == CNT_FULL && out_stall, cnt_q == CNT_FULL)
endmodule
